### design/dsm_pkg.sv
// ----------------------------------------------------------------------------
// dsm_pkg
// Shared types and constants of the dot-star pattern matcher: pattern byte
// layout, special pattern bytes and configuration register indexes.
// ----------------------------------------------------------------------------
package dsm_pkg;

    localparam int PATTERN_BYTES = 16;
    localparam int BYTE_W        = 8;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 2;
    localparam int LENGTH_W      = 5;

    localparam logic [BYTE_W-1:0] DOT_BYTE  = 8'h2E;
    localparam logic [BYTE_W-1:0] STAR_BYTE = 8'h2A;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2
    } cfg_reg_t;

    // byte 0 sits in the low bits
    typedef logic [PATTERN_BYTES-1:0][BYTE_W-1:0] pattern_t;

    typedef struct packed {
        pattern_t            pattern;
        logic [LENGTH_W-1:0] length;
    } pattern_cfg_t;

endpackage

### design/dsm_cfg_regs.sv
// ----------------------------------------------------------------------------
// dsm_cfg_regs
// Configuration registers: the two pattern byte words and the pattern length.
// ----------------------------------------------------------------------------
module dsm_cfg_regs
    import dsm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output pattern_cfg_t          pattern_cfg
);

    logic [CFG_DATA_W-1:0] pattern_low_reg;
    logic [CFG_DATA_W-1:0] pattern_high_reg;
    logic [LENGTH_W-1:0]   pattern_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LENGTH_W-1:0];
                default:            ;
            endcase
        end
    end

    assign pattern_cfg.pattern = {pattern_high_reg, pattern_low_reg};
    assign pattern_cfg.length  = pattern_length_reg;

endmodule

### design/dsm_column_update.sv
// ----------------------------------------------------------------------------
// dsm_column_update
// Next prefix match column from the current column and one item: a start
// item builds the empty-text column, a character item advances every prefix.
// ----------------------------------------------------------------------------
module dsm_column_update
    import dsm_pkg::*;
#(
    parameter int MAX_PATTERN = 16
)
(
    input  pattern_t               pattern,
    input  logic                   req_type,
    input  logic [BYTE_W-1:0]      text_char,
    input  logic [MAX_PATTERN:0]   column,
    output logic [MAX_PATTERN:0]   column_next
);

    // start item sets bit 0, a character item clears it
    assign column_next[0] = ~req_type;

    for (genvar i = 1; i <= MAX_PATTERN; i++)
    begin : g_prefix
        logic is_star;
        logic hit_cur;

        assign is_star = (pattern[i-1] == STAR_BYTE);
        assign hit_cur = (pattern[i-1] == text_char) || (pattern[i-1] == DOT_BYTE);

        if (i == 1)
        begin : g_first
            // a leading star matches nothing
            assign column_next[i] = ~is_star & req_type & hit_cur & column[i-1];
        end
        else
        begin : g_rest
            logic hit_prev;

            // a star before this one compares as a literal byte
            assign hit_prev = (pattern[i-2] == text_char) || (pattern[i-2] == DOT_BYTE);

            // star: zero copies from the new column, or one more copy
            assign column_next[i] = is_star
                ? (column_next[i-2] | (req_type & hit_prev & column[i]))
                : (req_type & hit_cur & column[i-1]);
        end
    end

endmodule

### design/dot_star_pattern_matcher_unit.sv
// ----------------------------------------------------------------------------
// dot_star_pattern_matcher_unit
// Whole-string matcher for patterns of literal bytes, '.' and '*'.
//
// The pattern (up to 16 bytes) and its length are written through the plain
// configuration port, by the user only while the block is idle; the block
// itself does not enforce this. Text streams in on the input channel one
// word at a time: req_type 0 starts a new text, req_type 1 carries one text
// byte. Every input word yields exactly one output word, matched, telling
// whether the text so far matches the whole pattern.
// A word accepted is first held in the input register, and when it moves
// on, the column of prefix match bits and the result register are updated
// together. Throughput is one word per cycle while the receiver does not
// stall, set by the single column update between the input and result
// registers. When the receiver stalls, the result holds and one more input
// word is taken into the input register; after that in_stall is raised.
// Reset clears the pattern to empty and sets the column to the empty-text
// state of the empty pattern.
// ----------------------------------------------------------------------------
module dot_star_pattern_matcher_unit
    import dsm_pkg::*;
#(
    parameter int MAX_PATTERN = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    input  logic [BYTE_W-1:0]     text_char,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  matched
);

    localparam int COL_W = MAX_PATTERN + 1;
    localparam int SEL_W = $clog2(MAX_PATTERN + 1);

    pattern_cfg_t       pattern_cfg;

    logic               stage_valid_reg;
    logic               stage_valid_next;
    logic               stage_req_reg;
    logic [BYTE_W-1:0]  stage_char_reg;

    logic [COL_W-1:0]   column_reg;
    logic [COL_W-1:0]   column_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               matched_reg;
    logic               matched_next;

    logic               in_accept;
    logic               advance;
    logic [SEL_W-1:0]   used_length;

    dsm_cfg_regs u_cfg_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pattern_cfg (pattern_cfg)
    );

    dsm_column_update #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_column_update (
        .pattern     (pattern_cfg.pattern),
        .req_type    (stage_req_reg),
        .text_char   (stage_char_reg),
        .column      (column_reg),
        .column_next (column_next)
    );

    // word moves to the result register when that slot is free or leaving
    assign advance   = stage_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = stage_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    assign stage_valid_next = in_accept || (stage_valid_reg && !advance);
    assign out_valid_next   = advance || (out_valid_reg && out_stall);

    // lengths beyond the tracked prefixes clamp to the longest one
    assign used_length = (pattern_cfg.length > LENGTH_W'(MAX_PATTERN))
        ? SEL_W'(MAX_PATTERN)
        : SEL_W'(pattern_cfg.length);

    assign matched_next = column_next[used_length];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            column_reg      <= COL_W'(1);
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            if (advance)
            begin
                column_reg <= column_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_req_reg  <= req_type;
            stage_char_reg <= text_char;
        end
        if (advance)
        begin
            matched_reg <= matched_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;

endmodule

### design/dsm_checker.sv
// ----------------------------------------------------------------------------
// dsm_checker
// Port-level checks of the matcher: result hold under stall, stall origin,
// stalled input word hold, the source of a fresh result, no idle result.
// ----------------------------------------------------------------------------
module dsm_checker
    import dsm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic              req_type,
    input  logic [BYTE_W-1:0] text_char,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic              matched
);

    // a stalled result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(matched))
    else $error("stalled result changed or dropped");

    // input side only backs up behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

    // a stalled input word stays put until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(req_type) && $stable(text_char))
    else $error("stalled input word changed or dropped");

    // a result appearing on an empty output came from an accepted input word
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a matching input word");

    // an idle block with nothing pending shows no result
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !$past(in_valid && !in_stall) |=> !out_valid)
    else $error("result appeared with no word in flight");

endmodule

bind dot_star_pattern_matcher_unit dsm_checker u_dsm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .text_char (text_char),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .matched   (matched)
);
